>>> rtl/affine_warp_nearest_sampler_defines.svh
// assertion macros for the affine warp sampler
// the asserting module provides clk and arst_n
`ifndef AFFINE_WARP_NEAREST_SAMPLER_DEFINES_SVH
`define AFFINE_WARP_NEAREST_SAMPLER_DEFINES_SVH

// consequence must hold in the same cycle as the trigger
`define AWNS_ASSERT_IMPLY(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

// consequence must hold after the trigger, delayed by dly
`define AWNS_ASSERT_AFTER(label, trig, cons, dly, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> ##dly (cons)) \
		else $error(msg);

`endif

>>> rtl/awns_pkg.sv
package awns_pkg;

	// default frame store edge length
	localparam int FRAME_SIZE_DEF = 1024;

	// field widths
	localparam int COEF_W = 32;
	localparam int CDIM_W = 11;
	localparam int COORD_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// mapping datapath widths
	localparam int PROD_W = COEF_W + COORD_W + 1;
	localparam int SUM_W = PROD_W + 1;
	localparam int SX_W = SUM_W + 1;
	localparam int FRAC_W = 16;
	localparam int HALF_Q = 32768;
	localparam int Q_ONE = 65536;

	// signed width for load placement, covers frame sizes up to 4096
	localparam int PLACE_W = 16;

	// item function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	// reset values of the registers
	localparam logic [CDIM_W-1:0] DIM_RESET = 11'd1024;
	localparam logic signed [COEF_W-1:0] COEF_UNIT = 32'sd65536;
	localparam logic signed [COEF_W-1:0] COEF_ZERO = 32'sd0;

	// fixed colours
	localparam logic [7:0] BLANK_LEVEL = 8'd50;
	localparam logic [7:0] FILL_RED = 8'd200;
	localparam logic [7:0] FILL_OTHER = 8'd60;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH,
		REG_SRC_HEIGHT,
		REG_COEF_XX,
		REG_COEF_XY,
		REG_COEF_XT,
		REG_COEF_YX,
		REG_COEF_YY,
		REG_COEF_YT
	} cfg_reg_t;

	typedef struct packed {
		logic              func;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [7:0]        red_in;
		logic [7:0]        green_in;
		logic [7:0]        blue_in;
		logic [7:0]        alpha_in;
	} item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
		logic       in_range;
	} result_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic [CDIM_W-1:0]        src_width;
		logic [CDIM_W-1:0]        src_height;
		logic signed [COEF_W-1:0] coef_xx;
		logic signed [COEF_W-1:0] coef_xy;
		logic signed [COEF_W-1:0] coef_xt;
		logic signed [COEF_W-1:0] coef_yx;
		logic signed [COEF_W-1:0] coef_yy;
		logic signed [COEF_W-1:0] coef_yt;
	} cfg_t;

	// per-item control handed from the mapper to the store
	typedef struct packed {
		logic valid;
		logic load;
		logic hit;
	} ctl_t;

endpackage

>>> rtl/awns_map.sv
module awns_map import awns_pkg::*; #(
	parameter int FRAME_SIZE = FRAME_SIZE_DEF,
	localparam int IDX_W = $clog2(FRAME_SIZE)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  item_t            item,
	input  cfg_t             cfg,
	output ctl_t             ctl_s4,
	output logic [IDX_W-1:0] row_s4,
	output logic [IDX_W-1:0] col_s4,
	output pixel_t           pix_s4
);

	localparam logic signed [SX_W-1:0] SX_FLOOR = -SX_W'(Q_ONE);
	localparam logic signed [SX_W-1:0] SX_LIMIT = SX_W'(FRAME_SIZE) <<< FRAC_W;
	localparam logic signed [PLACE_W-1:0] PLACE_LIMIT = PLACE_W'(FRAME_SIZE);

	// centring offset, halved toward zero
	function automatic logic signed [PLACE_W-1:0] centre_off(input logic [CDIM_W-1:0] dim);
		logic signed [PLACE_W-1:0] diff;
		logic signed [PLACE_W-1:0] rnd;
		diff = $signed(PLACE_W'(FRAME_SIZE)) - $signed(PLACE_W'(dim));
		rnd = diff + $signed(PLACE_W'(diff[PLACE_W-1]));
		return rnd >>> 1;
	endfunction

	// load placement
	logic signed [PLACE_W-1:0] lrow;
	logic signed [PLACE_W-1:0] lcol;
	logic lok;

	// products
	logic signed [PROD_W-1:0] pxx;
	logic signed [PROD_W-1:0] pxy;
	logic signed [PROD_W-1:0] pyx;
	logic signed [PROD_W-1:0] pyy;

	// stage registers
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic load_s1, load_s2, load_s3, load_s4;
	logic hit_s4;
	logic lok_s1, lok_s2, lok_s3;
	logic [IDX_W-1:0] lrow_s1, lrow_s2, lrow_s3;
	logic [IDX_W-1:0] lcol_s1, lcol_s2, lcol_s3;
	pixel_t pix_s1, pix_s2, pix_s3;
	logic signed [PROD_W-1:0] pxx_s1, pxy_s1, pyx_s1, pyy_s1;
	logic signed [SUM_W-1:0] sumx_s2, sumy_s2;
	logic signed [SX_W-1:0] sx_s3, sy_s3;

	// range check on the mapped point
	logic hitx, hity;
	logic [IDX_W-1:0] ix, iy;

	// placement of a loaded pixel in the store
	always_comb begin
		lrow = centre_off(cfg.src_height) + $signed(PLACE_W'(item.row));
		lcol = centre_off(cfg.src_width) + $signed(PLACE_W'(item.col));
		lok = !lrow[PLACE_W-1] && (lrow < PLACE_LIMIT)
			&& !lcol[PLACE_W-1] && (lcol < PLACE_LIMIT);
	end

	// matrix products
	always_comb begin
		pxx = cfg.coef_xx * $signed({1'b0, item.col});
		pxy = cfg.coef_xy * $signed({1'b0, item.row});
		pyx = cfg.coef_yx * $signed({1'b0, item.col});
		pyy = cfg.coef_yy * $signed({1'b0, item.row});
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage one: products and placement
	always_ff @(posedge clk) begin
		load_s1 <= (item.func == FUNC_LOAD);
		lok_s1 <= lok;
		lrow_s1 <= lrow[IDX_W-1:0];
		lcol_s1 <= lcol[IDX_W-1:0];
		pix_s1 <= '{alpha: item.alpha_in, blue: item.blue_in,
			green: item.green_in, red: item.red_in};
		pxx_s1 <= pxx;
		pxy_s1 <= pxy;
		pyx_s1 <= pyx;
		pyy_s1 <= pyy;
	end

	// stage two: sum the products
	always_ff @(posedge clk) begin
		load_s2 <= load_s1;
		lok_s2 <= lok_s1;
		lrow_s2 <= lrow_s1;
		lcol_s2 <= lcol_s1;
		pix_s2 <= pix_s1;
		sumx_s2 <= SUM_W'(pxx_s1) + SUM_W'(pxy_s1);
		sumy_s2 <= SUM_W'(pyx_s1) + SUM_W'(pyy_s1);
	end

	// stage three: add translation and one half
	always_ff @(posedge clk) begin
		load_s3 <= load_s2;
		lok_s3 <= lok_s2;
		lrow_s3 <= lrow_s2;
		lcol_s3 <= lcol_s2;
		pix_s3 <= pix_s2;
		sx_s3 <= SX_W'(sumx_s2) + SX_W'(cfg.coef_xt) + SX_W'(HALF_Q);
		sy_s3 <= SX_W'(sumy_s2) + SX_W'(cfg.coef_yt) + SX_W'(HALF_Q);
	end

	// truncate toward zero and test against the store
	always_comb begin
		hitx = (sx_s3 > SX_FLOOR) && (sx_s3 < SX_LIMIT);
		hity = (sy_s3 > SX_FLOOR) && (sy_s3 < SX_LIMIT);
		ix = (hitx && !sx_s3[SX_W-1]) ? sx_s3[FRAC_W +: IDX_W] : '0;
		iy = (hity && !sy_s3[SX_W-1]) ? sy_s3[FRAC_W +: IDX_W] : '0;
	end

	// stage four: pick load or sample address, out of range reads entry zero
	always_ff @(posedge clk) begin
		load_s4 <= load_s3;
		pix_s4 <= pix_s3;
		if (load_s3) begin
			hit_s4 <= lok_s3;
			row_s4 <= lok_s3 ? lrow_s3 : '0;
			col_s4 <= lok_s3 ? lcol_s3 : '0;
		end else begin
			hit_s4 <= hitx && hity;
			row_s4 <= (hitx && hity) ? iy : '0;
			col_s4 <= (hitx && hity) ? ix : '0;
		end
	end

	assign ctl_s4 = '{valid: valid_s4, load: load_s4, hit: hit_s4};

endmodule

>>> rtl/awns_store.sv
module awns_store import awns_pkg::*; #(
	parameter int FRAME_SIZE = FRAME_SIZE_DEF,
	localparam int IDX_W = $clog2(FRAME_SIZE)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl_s4,
	input  logic [IDX_W-1:0] row_s4,
	input  logic [IDX_W-1:0] col_s4,
	input  pixel_t           pix_s4,
	output logic             busy,
	output logic             strobe,
	output result_t          result
);

	localparam int DEPTH = FRAME_SIZE * FRAME_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int MEM_W = $bits(pixel_t) + 1;
	localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(FRAME_SIZE);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	// written flag on top of each pixel
	logic [MEM_W-1:0] mem [DEPTH];

	logic clearing_q;
	logic [ADDR_W-1:0] clr_q;

	logic valid_s5;
	logic load_s5;
	logic hit_s5;
	logic [ADDR_W-1:0] addr_s5;
	pixel_t pix_s5;

	logic valid_s6;
	logic hit_s6;
	logic [MEM_W-1:0] rd_s6;
	pixel_t rd_pix;

	logic strobe_q;
	result_t result_q;

	// flag clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q <= '0;
		end else if (clearing_q) begin
			if (clr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// control valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			valid_s5 <= ctl_s4.valid;
			valid_s6 <= valid_s5 && !load_s5;
			strobe_q <= valid_s6;
		end
	end

	// stage five: flat address
	always_ff @(posedge clk) begin
		load_s5 <= ctl_s4.load;
		hit_s5 <= ctl_s4.hit;
		pix_s5 <= pix_s4;
		addr_s5 <= ADDR_W'(row_s4) * ROW_PITCH + ADDR_W'(col_s4);
	end

	// frame store: sweep or load write, registered read
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_q] <= '0;
		end else if (valid_s5 && load_s5 && hit_s5) begin
			mem[addr_s5] <= {1'b1, pix_s5};
		end
		rd_s6 <= mem[addr_s5];
		hit_s6 <= hit_s5;
	end

	assign rd_pix = pixel_t'(rd_s6[MEM_W-2:0]);

	// result selection
	always_ff @(posedge clk) begin
		result_q.in_range <= hit_s6;
		if (!hit_s6) begin
			result_q.red_out <= FILL_RED;
			result_q.green_out <= FILL_OTHER;
			result_q.blue_out <= FILL_OTHER;
			result_q.alpha_out <= FILL_OTHER;
		end else if (!rd_s6[MEM_W-1]) begin
			result_q.red_out <= BLANK_LEVEL;
			result_q.green_out <= BLANK_LEVEL;
			result_q.blue_out <= BLANK_LEVEL;
			result_q.alpha_out <= BLANK_LEVEL;
		end else begin
			result_q.red_out <= rd_pix.red;
			result_q.green_out <= rd_pix.green;
			result_q.blue_out <= rd_pix.blue;
			result_q.alpha_out <= rd_pix.alpha;
		end
	end

	assign busy = clearing_q;
	assign strobe = strobe_q;
	assign result = result_q;

endmodule

>>> rtl/affine_warp_nearest_sampler.sv
// Inverse affine warp sampler, nearest neighbour, over a square frame store.
// Items enter on start while busy is low, one per clock. item.func selects:
// load writes a source pixel, centred in the store by the source width and
// height; sample maps (col, row) through the inverse matrix and returns
// the stored pixel, grey 50 for an entry never loaded, or the fill colour
// 200,60,60,60 with in_range low when the point falls outside the store.
// Loads give no result. A sample result appears on result for one cycle with
// strobe high, after the mapping, address, read and result stages; results
// come in item order and a load is seen by every sample taken after it.
// Throughput is one item per clock while busy is low: the mapping runs as a
// four stage pipeline (products, sum, offset, range check) feeding a store
// that can write and read at once. The receiver has no way to hold results
// off, so nothing ever stalls. After reset the written flags are swept clear,
// one entry per clock; busy is high until all FRAME_SIZE*FRAME_SIZE entries
// (1048576 by default) are clear. Registers are written through cfg_we,
// cfg_index and cfg_data, by the user only while the pipeline is empty, the
// sweep included, unchecked by the block; they reset to an identity map.
`include "affine_warp_nearest_sampler_defines.svh"

module affine_warp_nearest_sampler import awns_pkg::*; #(
	parameter int FRAME_SIZE = FRAME_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	output logic                  strobe,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(FRAME_SIZE);
	localparam int LATENCY = 7;

	cfg_t cfg_q;
	logic take;
	ctl_t ctl_s4;
	logic [IDX_W-1:0] row_s4;
	logic [IDX_W-1:0] col_s4;
	pixel_t pix_s4;

	assign take = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width <= DIM_RESET;
			cfg_q.src_height <= DIM_RESET;
			cfg_q.coef_xx <= COEF_UNIT;
			cfg_q.coef_xy <= COEF_ZERO;
			cfg_q.coef_xt <= COEF_ZERO;
			cfg_q.coef_yx <= COEF_ZERO;
			cfg_q.coef_yy <= COEF_UNIT;
			cfg_q.coef_yt <= COEF_ZERO;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SRC_WIDTH: cfg_q.src_width <= cfg_data[CDIM_W-1:0];
				REG_SRC_HEIGHT: cfg_q.src_height <= cfg_data[CDIM_W-1:0];
				REG_COEF_XX: cfg_q.coef_xx <= $signed(cfg_data[COEF_W-1:0]);
				REG_COEF_XY: cfg_q.coef_xy <= $signed(cfg_data[COEF_W-1:0]);
				REG_COEF_XT: cfg_q.coef_xt <= $signed(cfg_data[COEF_W-1:0]);
				REG_COEF_YX: cfg_q.coef_yx <= $signed(cfg_data[COEF_W-1:0]);
				REG_COEF_YY: cfg_q.coef_yy <= $signed(cfg_data[COEF_W-1:0]);
				REG_COEF_YT: cfg_q.coef_yt <= $signed(cfg_data[COEF_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	// coordinate mapping and load placement
	awns_map #(
		.FRAME_SIZE(FRAME_SIZE)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item),
		.cfg    (cfg_q),
		.ctl_s4 (ctl_s4),
		.row_s4 (row_s4),
		.col_s4 (col_s4),
		.pix_s4 (pix_s4)
	);

	// frame store and result stage
	awns_store #(
		.FRAME_SIZE(FRAME_SIZE)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s4 (ctl_s4),
		.row_s4 (row_s4),
		.col_s4 (col_s4),
		.pix_s4 (pix_s4),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	// every sample gives one result, every load none
	`AWNS_ASSERT_AFTER(a_sample_result, take && item.func == FUNC_SAMPLE, strobe, LATENCY, "sample item lost")
	`AWNS_ASSERT_AFTER(a_load_silent, take && item.func == FUNC_LOAD, !strobe, LATENCY, "load item gave a result")
	// no result while the flags are being swept
	`AWNS_ASSERT_IMPLY(a_quiet_sweep, busy, !strobe, "result during flag sweep")
	// a miss always carries the fill colour
	`AWNS_ASSERT_IMPLY(a_miss_fill, strobe && !result.in_range, result.red_out == FILL_RED && result.alpha_out == FILL_OTHER, "miss without fill colour")

endmodule
